// ----- rtl/core/hrp_pkg.sv -----
// Package with the types, codes and character tables of the request header parser.
package hrp_pkg;

    localparam logic [3:0] PH_METHOD = 4'd0;
    localparam logic [3:0] PH_SKIP   = 4'd1;
    localparam logic [3:0] PH_PATH   = 4'd2;
    localparam logic [3:0] PH_QSTART = 4'd3;
    localparam logic [3:0] PH_QKEY   = 4'd4;
    localparam logic [3:0] PH_QVAL   = 4'd5;
    localparam logic [3:0] PH_QDROP  = 4'd6;
    localparam logic [3:0] PH_VER    = 4'd7;
    localparam logic [3:0] PH_VREST  = 4'd8;
    localparam logic [3:0] PH_HKEY0  = 4'd9;
    localparam logic [3:0] PH_HKEY   = 4'd10;
    localparam logic [3:0] PH_HVAL   = 4'd11;
    localparam logic [3:0] PH_BAD    = 4'd12;
    localparam logic [3:0] PH_BODY   = 4'd13;
    localparam logic [3:0] PH_ERR    = 4'd14;

    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_CR    = 2'd1;
    localparam logic [1:0] HOLD_COLON = 2'd2;

    localparam logic [2:0] TAG_DELIM = 3'd0;
    localparam logic [2:0] TAG_PATH  = 3'd1;
    localparam logic [2:0] TAG_QKEY  = 3'd2;
    localparam logic [2:0] TAG_QVAL  = 3'd3;
    localparam logic [2:0] TAG_VER   = 3'd4;
    localparam logic [2:0] TAG_HKEY  = 3'd5;
    localparam logic [2:0] TAG_HVAL  = 3'd6;
    localparam logic [2:0] TAG_BODY  = 3'd7;

    localparam logic [2:0] ST_RUNNING    = 3'd0;
    localparam logic [2:0] ST_COMPLETE   = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE = 3'd2;
    localparam logic [2:0] ST_NO_LINE    = 3'd3;
    localparam logic [2:0] ST_BAD_METHOD = 3'd4;
    localparam logic [2:0] ST_NO_PATH    = 3'd5;
    localparam logic [2:0] ST_BAD_VER    = 3'd6;
    localparam logic [2:0] ST_NO_SEP     = 3'd7;

    localparam logic [1:0] METH_GET    = 2'd0;
    localparam logic [1:0] METH_POST   = 2'd1;
    localparam logic [1:0] METH_PUT    = 2'd2;
    localparam logic [1:0] METH_DELETE = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] midx;
        logic [1:0] meth;
        logic       ver;
        logic [1:0] hold;
        logic [2:0] fstat;
    } state_t;

    typedef struct packed {
        state_t     st;
        logic [2:0] tag;
    } cls_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] byte0;
        logic [2:0] tag0;
        logic [7:0] byte1;
        logic [2:0] tag1;
        logic [1:0] meth;
        logic       ver;
        logic [2:0] status;
    } wr_t;

    typedef struct packed {
        logic       run_last;
        logic [2:0] status;
        logic       ver;
        logic [1:0] meth;
        logic [2:0] tag;
        logic [7:0] out_byte;
    } item_t;

    localparam state_t STATE_RESET = '{
        phase: PH_METHOD, midx: 3'd0, meth: METH_GET, ver: 1'b0,
        hold: HOLD_NONE, fstat: ST_RUNNING
    };

    function automatic logic [2:0] meth_len(logic [1:0] m);
        logic [2:0] len;
        unique case (m)
            METH_GET:    len = 3'd3;
            METH_POST:   len = 3'd4;
            METH_PUT:    len = 3'd3;
            METH_DELETE: len = 3'd6;
            default:     len = 3'd3;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] meth_char(logic [1:0] m, logic [2:0] i);
        logic [7:0] c;
        unique case ({m, i})
            {METH_GET, 3'd0}:    c = "G";
            {METH_GET, 3'd1}:    c = "E";
            {METH_GET, 3'd2}:    c = "T";
            {METH_POST, 3'd0}:   c = "P";
            {METH_POST, 3'd1}:   c = "O";
            {METH_POST, 3'd2}:   c = "S";
            {METH_POST, 3'd3}:   c = "T";
            {METH_PUT, 3'd0}:    c = "P";
            {METH_PUT, 3'd1}:    c = "U";
            {METH_PUT, 3'd2}:    c = "T";
            {METH_DELETE, 3'd0}: c = "D";
            {METH_DELETE, 3'd1}: c = "E";
            {METH_DELETE, 3'd2}: c = "L";
            {METH_DELETE, 3'd3}: c = "E";
            {METH_DELETE, 3'd4}: c = "T";
            {METH_DELETE, 3'd5}: c = "E";
            default:             c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ver_char(logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            3'd5:    c = "1";
            3'd6:    c = ".";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_terminal(state_t s);
        return (s.phase == PH_BODY) || (s.phase == PH_ERR);
    endfunction

    // Tags one byte that is not part of a line-ending pair and advances the state.
    function automatic cls_t classify(state_t s_in, logic [7:0] b);
        cls_t       r;
        logic [2:0] i;
        logic       bad;
        r.st  = s_in;
        r.tag = TAG_DELIM;
        i     = s_in.midx;
        bad   = 1'b0;
        unique case (s_in.phase)
            PH_METHOD: begin
                if (i == 3'd0) begin
                    if (b == "G") r.st.meth = METH_GET;
                    else if (b == "P") r.st.meth = METH_POST;
                    else if (b == "D") r.st.meth = METH_DELETE;
                    else bad = 1'b1;
                end else if (i == 3'd1 && s_in.meth == METH_POST && b == "U") begin
                    r.st.meth = METH_PUT;
                end
                if (!bad) begin
                    if (i >= meth_len(r.st.meth) || meth_char(r.st.meth, i) != b) begin
                        bad = 1'b1;
                    end else begin
                        r.st.midx = i + 3'd1;
                        if ((i + 3'd1) == meth_len(r.st.meth)) r.st.phase = PH_SKIP;
                    end
                end
                if (bad) begin
                    r.st.fstat = ST_BAD_METHOD;
                    r.st.phase = PH_BAD;
                end
            end
            PH_SKIP: begin
                r.st.phase = PH_PATH;
            end
            PH_PATH: begin
                if (b == CH_SP) begin
                    r.st.phase = PH_VER;
                    r.st.midx  = 3'd0;
                end else if (b == CH_QMARK) begin
                    r.st.phase = PH_QSTART;
                end else begin
                    r.tag = TAG_PATH;
                end
            end
            PH_QSTART, PH_QKEY, PH_QVAL, PH_QDROP: begin
                if (b == CH_SP) begin
                    r.st.phase = PH_VER;
                    r.st.midx  = 3'd0;
                end else if (b == CH_AMP) begin
                    r.st.phase = PH_QSTART;
                end else if (s_in.phase == PH_QSTART) begin
                    if (b == CH_EQ) begin
                        r.st.phase = PH_QDROP;
                    end else begin
                        r.st.phase = PH_QKEY;
                        r.tag      = TAG_QKEY;
                    end
                end else if (s_in.phase == PH_QKEY) begin
                    if (b == CH_EQ) r.st.phase = PH_QVAL;
                    else r.tag = TAG_QKEY;
                end else if (s_in.phase == PH_QVAL) begin
                    r.tag = TAG_QVAL;
                end
            end
            PH_VER: begin
                if (i != 3'd7) begin
                    if (ver_char(i) != b) begin
                        r.st.fstat = ST_BAD_VER;
                        r.st.phase = PH_BAD;
                    end else begin
                        r.st.midx = i + 3'd1;
                        r.tag     = TAG_VER;
                    end
                end else if (b == "0" || b == "1") begin
                    r.st.ver   = (b == "1");
                    r.st.phase = PH_VREST;
                    r.tag      = TAG_VER;
                end else begin
                    r.st.fstat = ST_BAD_VER;
                    r.st.phase = PH_BAD;
                end
            end
            PH_HKEY0, PH_HKEY: begin
                r.st.phase = PH_HKEY;
                r.tag      = TAG_HKEY;
            end
            PH_HVAL: r.tag = TAG_HVAL;
            PH_BODY: r.tag = TAG_BODY;
            default: r.tag = TAG_DELIM;
        endcase
        return r;
    endfunction

    // Applies a CR LF pair to the state.
    function automatic state_t line_end(state_t s_in);
        state_t s;
        s = s_in;
        unique case (s_in.phase)
            PH_METHOD: begin
                s.fstat = (s_in.midx == 3'd0) ? ST_NO_LINE : ST_BAD_METHOD;
                s.phase = PH_ERR;
            end
            PH_SKIP, PH_PATH, PH_QSTART, PH_QKEY, PH_QVAL, PH_QDROP: begin
                s.fstat = ST_NO_PATH;
                s.phase = PH_ERR;
            end
            PH_VER: begin
                s.fstat = ST_BAD_VER;
                s.phase = PH_ERR;
            end
            PH_VREST, PH_HVAL: s.phase = PH_HKEY0;
            PH_HKEY0: begin
                s.fstat = ST_COMPLETE;
                s.phase = PH_BODY;
            end
            PH_HKEY: begin
                s.fstat = ST_NO_SEP;
                s.phase = PH_ERR;
            end
            PH_BAD: s.phase = PH_ERR;
            default: s = s_in;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/core/hrp_step.sv -----
// Parser state register and the per-byte tagging logic that produces up to two results.
module hrp_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step_en,
    input  logic [7:0]     step_byte,
    input  logic           step_last,
    output hrp_pkg::wr_t   wr
);

    hrp_pkg::state_t state_reg;
    hrp_pkg::state_t state_next;

    hrp_pkg::state_t s;
    hrp_pkg::cls_t   c;
    logic [1:0]      n;
    logic            done;
    logic [7:0]      hb;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [2:0]      t0;
    logic [2:0]      t1;

    always_comb begin
        s    = state_reg;
        n    = 2'd0;
        done = 1'b0;
        b0   = 8'h00;
        b1   = 8'h00;
        t0   = hrp_pkg::TAG_DELIM;
        t1   = hrp_pkg::TAG_DELIM;
        hb   = hrp_pkg::CH_CR;
        c    = '0;

        if (s.hold == hrp_pkg::HOLD_CR) begin
            s.hold = hrp_pkg::HOLD_NONE;
            if (step_byte == hrp_pkg::CH_LF) begin
                b0   = hrp_pkg::CH_CR;
                s    = hrp_pkg::line_end(s);
                b1   = hrp_pkg::CH_LF;
                n    = 2'd2;
                done = 1'b1;
            end else begin
                c  = hrp_pkg::classify(s, hrp_pkg::CH_CR);
                s  = c.st;
                b0 = hrp_pkg::CH_CR;
                t0 = c.tag;
                n  = 2'd1;
            end
        end else if (s.hold == hrp_pkg::HOLD_COLON) begin
            s.hold = hrp_pkg::HOLD_NONE;
            if (step_byte == hrp_pkg::CH_SP) begin
                b0      = hrp_pkg::CH_COLON;
                s.phase = hrp_pkg::PH_HVAL;
                b1      = hrp_pkg::CH_SP;
                n       = 2'd2;
                done    = 1'b1;
            end else begin
                c  = hrp_pkg::classify(s, hrp_pkg::CH_COLON);
                s  = c.st;
                b0 = hrp_pkg::CH_COLON;
                t0 = c.tag;
                n  = 2'd1;
            end
        end

        if (!done) begin
            if (step_byte == hrp_pkg::CH_CR && !hrp_pkg::is_terminal(s)) begin
                s.hold = hrp_pkg::HOLD_CR;
            end else if (step_byte == hrp_pkg::CH_COLON &&
                         (s.phase == hrp_pkg::PH_HKEY0 || s.phase == hrp_pkg::PH_HKEY)) begin
                s.hold = hrp_pkg::HOLD_COLON;
            end else begin
                c = hrp_pkg::classify(s, step_byte);
                s = c.st;
                if (n == 2'd0) begin
                    b0 = step_byte;
                    t0 = c.tag;
                end else begin
                    b1 = step_byte;
                    t1 = c.tag;
                end
                n = n + 2'd1;
            end
        end

        if (step_last) begin
            if (s.hold != hrp_pkg::HOLD_NONE) begin
                hb     = (s.hold == hrp_pkg::HOLD_CR) ? hrp_pkg::CH_CR : hrp_pkg::CH_COLON;
                s.hold = hrp_pkg::HOLD_NONE;
                c      = hrp_pkg::classify(s, hb);
                s      = c.st;
                if (n == 2'd0) begin
                    b0 = hb;
                    t0 = c.tag;
                end else begin
                    b1 = hb;
                    t1 = c.tag;
                end
                n = n + 2'd1;
            end
            if (!hrp_pkg::is_terminal(s)) begin
                s.fstat = hrp_pkg::ST_INCOMPLETE;
                s.phase = hrp_pkg::PH_ERR;
            end
        end

        wr.cnt    = step_en ? n : 2'd0;
        wr.byte0  = b0;
        wr.tag0   = t0;
        wr.byte1  = b1;
        wr.tag1   = t1;
        wr.meth   = s.meth;
        wr.ver    = s.ver;
        wr.status = hrp_pkg::is_terminal(s) ? s.fstat : hrp_pkg::ST_RUNNING;

        state_next = step_last ? hrp_pkg::STATE_RESET : s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrp_pkg::STATE_RESET;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/hrp_outq.sv -----
// Result queue that takes up to two items per cycle and hands out one per cycle while out_ready is high.
module hrp_outq (
    input  logic           aclk,
    input  logic           aresetn,
    input  hrp_pkg::wr_t   wr,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output hrp_pkg::item_t out_item
);

    hrp_pkg::item_t entry_reg [hrp_pkg::QDEPTH];
    logic [hrp_pkg::QAW-1:0] rd_ptr_reg;
    logic [hrp_pkg::QAW-1:0] rd_ptr_next;
    logic [hrp_pkg::QAW-1:0] wr_ptr_reg;
    logic [hrp_pkg::QAW-1:0] wr_ptr_next;
    logic [hrp_pkg::QAW-1:0] wr_ptr_inc;
    logic [hrp_pkg::QCW-1:0] count_reg;
    logic [hrp_pkg::QCW-1:0] count_next;
    hrp_pkg::item_t e0;
    hrp_pkg::item_t e1;
    logic pop;

    localparam logic [hrp_pkg::QCW-1:0] ROOM_MAX = hrp_pkg::QCW'(hrp_pkg::QDEPTH - 2);

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= ROOM_MAX);

    assign e0 = '{run_last: (wr.cnt == 2'd1), status: wr.status, ver: wr.ver,
                  meth: wr.meth, tag: wr.tag0, out_byte: wr.byte0};
    assign e1 = '{run_last: 1'b1, status: wr.status, ver: wr.ver,
                  meth: wr.meth, tag: wr.tag1, out_byte: wr.byte1};

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + hrp_pkg::QAW'(wr.cnt);
    assign rd_ptr_next = rd_ptr_reg + hrp_pkg::QAW'(pop);
    assign count_next  = count_reg + hrp_pkg::QCW'(wr.cnt) - hrp_pkg::QCW'(pop);

    always_ff @(posedge aclk) begin
        if (wr.cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= e0;
        end
        if (wr.cnt == 2'd2) begin
            entry_reg[wr_ptr_inc] <= e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/http_request_header_parser.sv -----
// Top level of the request header parser: input register, tagging step and result queue.
//
//   Channel  Direction  tdata                          tuser      tlast
//   s_       in         data_byte[7:0]                 -          buffer_end
//   m_       out        out_byte, method, version,     tag[2:0]   run_last
//                       status (padded to 16 bits)
//
// One byte is accepted per cycle while the queue has room; a byte is held in the input
// register and its results in the result queue before they appear. A byte that yields two
// results writes both into the four-entry result queue at once; they leave it one at a time.
// A byte that is held (CR or colon) yields no result until the next byte or the buffer end.
// Reset clears the parser state and empties the queue; m_tready low stalls
// input once the queue has fewer than two free entries.
module http_request_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] method, [10] version, [13:11] status
    output logic [2:0]  m_tuser,   // [2:0] tag
    output logic        m_tlast
);

    logic           in_valid_reg;
    logic           in_valid_next;
    logic [7:0]     in_byte_reg;
    logic           in_last_reg;
    logic           advance;
    logic           room;
    hrp_pkg::wr_t   wr;
    hrp_pkg::item_t item;

    assign advance       = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hrp_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .step_byte (in_byte_reg),
        .step_last (in_last_reg),
        .wr        (wr)
    );

    hrp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {2'b00, item.status, item.ver, item.meth, item.out_byte};
    assign m_tuser = item.tag;
    assign m_tlast = item.run_last;

endmodule

// ----- rtl/core/hrp_checker.sv -----
// Port-level checks of the request header parser and their bind to the top level.
module hrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_run_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[13:8] == $past(m_tdata[13:8]))
        else $error("second item of a byte missing or with other method, version or status");

    a_body_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hrp_pkg::TAG_BODY |-> m_tdata[13:11] == hrp_pkg::ST_COMPLETE)
        else $error("body item without a complete header");

    a_field_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != hrp_pkg::TAG_DELIM && m_tuser != hrp_pkg::TAG_BODY
            |-> m_tdata[13:11] == hrp_pkg::ST_RUNNING
                || m_tdata[13:11] == hrp_pkg::ST_INCOMPLETE)
        else $error("field item carries a final status");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (.*);
